@@ sv/msl_pkg.sv @@
// Shared types, character codes and helper functions for the memory-set line parser.
`timescale 1ns / 1ps

package msl_pkg;

    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned OFFSET_W = 9;
    localparam int unsigned COUNT_W  = 8;
    localparam int unsigned NIBBLE_W = 4;
    localparam int unsigned APB_DW   = 32;
    localparam int unsigned APB_AW   = 3;

    localparam logic [CHAR_W-1:0] CHAR_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_DQUOTE = 8'h22;
    localparam logic [CHAR_W-1:0] CHAR_SQUOTE = 8'h27;

    localparam logic REQ_CHAR = 1'b0;
    localparam logic REQ_EOL  = 1'b1;

    // Register index taken from the word address.
    localparam logic REG_START_OFFSET = 1'b0;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_DQUOTE = 2'd1,
        MODE_SQUOTE = 2'd2,
        MODE_ABORT  = 2'd3
    } t_mode;

    typedef struct packed {
        t_mode                mode;
        logic                 pending;
        logic [NIBBLE_W-1:0]  high_nibble;
        logic [COUNT_W-1:0]   count;
    } t_state;

    typedef struct packed {
        logic                 write_valid;
        logic [CHAR_W-1:0]    byte_value;
        logic [OFFSET_W-1:0]  byte_offset;
        logic                 syntax_error;
        logic                 line_done;
    } t_result;

    function automatic logic is_hex(input logic [CHAR_W-1:0] c);
        return (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
    endfunction

    function automatic logic [NIBBLE_W-1:0] hex_of(input logic [CHAR_W-1:0] c);
        logic [NIBBLE_W-1:0] v;
        v = '0;
        if (c inside {[8'h30:8'h39]}) begin
            v = c[3:0];
        end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            // 'A'/'a' end in 1, so low three bits plus 9 gives 10..15
            v = 4'(c[2:0]) + 4'd9;
        end
        return v;
    endfunction

endpackage

@@ sv/msl_if.sv @@
// Valid/ready channel interfaces for parser requests and results.
`timescale 1ns / 1ps

interface msl_req_if;
    logic                        valid;
    logic                        ready;
    logic                        req_type;
    logic [msl_pkg::CHAR_W-1:0]  char_code;

    modport source (output valid, output req_type, output char_code, input ready);
    modport sink   (input valid, input req_type, input char_code, output ready);
endinterface

interface msl_res_if;
    logic                          valid;
    logic                          ready;
    logic                          write_valid;
    logic [msl_pkg::CHAR_W-1:0]    byte_value;
    logic [msl_pkg::OFFSET_W-1:0]  byte_offset;
    logic                          syntax_error;
    logic                          line_done;

    modport source (output valid, output write_valid, output byte_value,
                    output byte_offset, output syntax_error, output line_done,
                    input ready);
    modport sink   (input valid, input write_valid, input byte_value,
                    input byte_offset, input syntax_error, input line_done,
                    output ready);
endinterface

@@ sv/memory_set_line_parser_core.sv @@
// Top level of the memory-set line parser: input stage, parse step, result stage.
`timescale 1ns / 1ps

// Usage:
//   i_req carries one line character (req_type 0) or the end-of-line marker
//   (req_type 1) per transaction. o_res returns exactly one result per request:
//   a byte to store with its sector offset, the syntax-error flag, and
//   line_done on the end-of-line result.
//   The APB port holds start_offset at byte address 0; write it only while
//   no request is in flight.
// Pipeline and throughput:
//   A request lands in the input register, passes the parse step, and its
//   result is registered in the result stage, which drives o_res.valid. One
//   transaction per cycle is sustained while o_res.ready stays high; the line
//   state (mode, pending nibble, byte count) updates as the request leaves
//   the input register, so nothing else limits the rate.
// Reset (synchronous, active low):
//   Drop both stages, clear the line state and set start_offset to zero.
// Stall:
//   When o_res.ready is low the result stage holds; the input register
//   still takes one more transaction, then i_req.ready drops until the
//   result moves on.
module memory_set_line_parser_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    msl_req_if.sink                        i_req,
    msl_res_if.source                      o_res,
    input  logic                           i_psel,
    input  logic                           i_penable,
    input  logic                           i_pwrite,
    input  logic [msl_pkg::APB_AW-1:0]     i_paddr,
    input  logic [msl_pkg::APB_DW-1:0]     i_pwdata,
    output logic [msl_pkg::APB_DW-1:0]     o_prdata,
    output logic                           o_pready
);

    logic [msl_pkg::OFFSET_W-1:0] w_start_offset;

    // Input register
    logic                       r_in_valid;
    logic                       r_in_type;
    logic [msl_pkg::CHAR_W-1:0] r_in_char;

    // Line state and result register
    msl_pkg::t_state            r_state;
    msl_pkg::t_state            n_state;
    msl_pkg::t_result           n_res;
    msl_pkg::t_result           r_res;
    logic                       r_out_valid;

    logic                       w_advance;
    logic                       w_in_take;

    msl_apb u_apb (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_psel         (i_psel),
        .i_penable      (i_penable),
        .i_pwrite       (i_pwrite),
        .i_paddr        (i_paddr),
        .i_pwdata       (i_pwdata),
        .o_prdata       (o_prdata),
        .o_pready       (o_pready),
        .o_start_offset (w_start_offset)
    );

    msl_step u_step (
        .i_req_type     (r_in_type),
        .i_char         (r_in_char),
        .i_state        (r_state),
        .i_start_offset (w_start_offset),
        .o_state        (n_state),
        .o_result       (n_res)
    );

    // Advance the held request into the result stage when that stage is free
    // or being emptied this cycle.
    assign w_advance   = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_req.ready = !r_in_valid || w_advance;
    assign w_in_take   = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_type <= i_req.req_type;
            r_in_char <= i_req.char_code;
        end
    end

    // The line state commits only as a request moves to the result stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{mode: msl_pkg::MODE_NORMAL, pending: 1'b0,
                         high_nibble: '0, count: '0};
        end else if (w_advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.write_valid  = r_res.write_valid;
    assign o_res.byte_value   = r_res.byte_value;
    assign o_res.byte_offset  = r_res.byte_offset;
    assign o_res.syntax_error = r_res.syntax_error;
    assign o_res.line_done    = r_res.line_done;

`ifndef SYNTHESIS
    // A pending hex digit only exists in normal mode.
    a_pending_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.pending |-> (r_state.mode == msl_pkg::MODE_NORMAL))
        else $error("nibble pending outside normal mode");

    // An end-of-line request leaves a clean line state behind.
    a_eol_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && (r_in_type == msl_pkg::REQ_EOL)) |=>
        (r_state.count == '0) && !r_state.pending &&
        (r_state.mode == msl_pkg::MODE_NORMAL))
        else $error("line state not cleared at end of line");

    // A result without a byte carries zero value and offset.
    a_idle_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_res.write_valid) |->
        (r_res.byte_value == '0) && (r_res.byte_offset == '0))
        else $error("nonzero payload on a result without a byte");

    // An empty result stage never blocks the input side.
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_req.ready)
        else $error("input stalled with empty result stage");
`endif

endmodule

@@ sv/msl_apb.sv @@
// APB register block holding the start offset.
`timescale 1ns / 1ps

module msl_apb (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_psel,
    input  logic                           i_penable,
    input  logic                           i_pwrite,
    input  logic [msl_pkg::APB_AW-1:0]     i_paddr,
    input  logic [msl_pkg::APB_DW-1:0]     i_pwdata,
    output logic [msl_pkg::APB_DW-1:0]     o_prdata,
    output logic                           o_pready,
    output logic [msl_pkg::OFFSET_W-1:0]   o_start_offset
);

    logic [msl_pkg::OFFSET_W-1:0] r_start_offset;
    logic                         w_sel_start;

    assign o_pready    = 1'b1;
    assign w_sel_start = (i_paddr[2] == msl_pkg::REG_START_OFFSET);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_offset <= '0;
        end else if (i_psel && i_penable && i_pwrite && o_pready && w_sel_start) begin
            r_start_offset <= i_pwdata[msl_pkg::OFFSET_W-1:0];
        end
    end

    always_comb begin
        o_prdata = '0;
        if (w_sel_start) begin
            o_prdata = {{(msl_pkg::APB_DW-msl_pkg::OFFSET_W){1'b0}}, r_start_offset};
        end
    end

    assign o_start_offset = r_start_offset;

endmodule

@@ sv/msl_step.sv @@
// One parse step: decodes a character or the end-of-line marker against the line state.
`timescale 1ns / 1ps

module msl_step (
    input  logic                           i_req_type,
    input  logic [msl_pkg::CHAR_W-1:0]     i_char,
    input  msl_pkg::t_state                i_state,
    input  logic [msl_pkg::OFFSET_W-1:0]   i_start_offset,
    output msl_pkg::t_state                o_state,
    output msl_pkg::t_result               o_result
);

    logic                       w_emit;
    logic [msl_pkg::CHAR_W-1:0] w_byte;

    // Outputs
    always_comb begin
        w_emit                = 1'b0;
        w_byte                = '0;
        o_result              = '0;
        if (i_req_type == msl_pkg::REQ_EOL) begin
            o_result.line_done = 1'b1;
            if (i_state.mode == msl_pkg::MODE_ABORT) begin
                o_result.syntax_error = 1'b1;
            end else if (i_state.pending) begin
                w_emit = 1'b1;
                w_byte = {i_state.high_nibble, 4'h0};
            end
        end else begin
            case (i_state.mode)
                msl_pkg::MODE_DQUOTE: begin
                    if (i_char != msl_pkg::CHAR_DQUOTE) begin
                        w_emit = 1'b1;
                        w_byte = i_char;
                    end
                end
                msl_pkg::MODE_SQUOTE: begin
                    if (i_char != msl_pkg::CHAR_SQUOTE) begin
                        w_emit = 1'b1;
                        if (i_char inside {[8'h41:8'h5a], [8'h61:8'h7a]}) begin
                            w_byte = {3'b000, i_char[4:0]};
                        end else begin
                            w_byte = i_char;
                        end
                    end
                end
                msl_pkg::MODE_ABORT: begin
                    o_result.syntax_error = 1'b1;
                end
                default: begin
                    if (i_state.pending) begin
                        w_emit = 1'b1;
                        if (i_char == msl_pkg::CHAR_SPACE) begin
                            w_byte = {4'h0, i_state.high_nibble};
                        end else begin
                            w_byte = {i_state.high_nibble, msl_pkg::hex_of(i_char)};
                        end
                    end else if (!(i_char inside {msl_pkg::CHAR_SPACE, msl_pkg::CHAR_DQUOTE,
                                                  msl_pkg::CHAR_SQUOTE})
                                 && !msl_pkg::is_hex(i_char)) begin
                        o_result.syntax_error = 1'b1;
                    end
                end
            endcase
        end
        if (w_emit) begin
            o_result.write_valid = 1'b1;
            o_result.byte_value  = w_byte;
            o_result.byte_offset = msl_pkg::OFFSET_W'(i_start_offset
                                   + {1'b0, i_state.count});
        end
    end

    // Next state
    always_comb begin
        o_state = i_state;
        if (w_emit) begin
            o_state.count = i_state.count + 8'd1;
        end
        if (i_req_type == msl_pkg::REQ_EOL) begin
            o_state = '{mode: msl_pkg::MODE_NORMAL, pending: 1'b0,
                        high_nibble: '0, count: '0};
        end else begin
            case (i_state.mode)
                msl_pkg::MODE_DQUOTE: begin
                    if (i_char == msl_pkg::CHAR_DQUOTE) begin
                        o_state.mode = msl_pkg::MODE_NORMAL;
                    end
                end
                msl_pkg::MODE_SQUOTE: begin
                    if (i_char == msl_pkg::CHAR_SQUOTE) begin
                        o_state.mode = msl_pkg::MODE_NORMAL;
                    end
                end
                msl_pkg::MODE_ABORT: begin
                    o_state.mode = msl_pkg::MODE_ABORT;
                end
                default: begin
                    if (i_state.pending) begin
                        o_state.pending     = 1'b0;
                        o_state.high_nibble = '0;
                    end else if (i_char == msl_pkg::CHAR_SPACE) begin
                        o_state.mode = msl_pkg::MODE_NORMAL;
                    end else if (i_char == msl_pkg::CHAR_DQUOTE) begin
                        o_state.mode = msl_pkg::MODE_DQUOTE;
                    end else if (i_char == msl_pkg::CHAR_SQUOTE) begin
                        o_state.mode = msl_pkg::MODE_SQUOTE;
                    end else if (msl_pkg::is_hex(i_char)) begin
                        o_state.pending     = 1'b1;
                        o_state.high_nibble = msl_pkg::hex_of(i_char);
                    end else begin
                        o_state.mode = msl_pkg::MODE_ABORT;
                    end
                end
            endcase
        end
    end

endmodule
